// ===== rtl/core/gdr_pkg.sv =====
// gdr_pkg: widths, register codes, reset values and shared types of the
// grouped decimal render unit. No dependencies.
`default_nettype none

package gdr_pkg;

    // widths of the request and result fields
    localparam int NUM_W = 64;
    localparam int CAP_W = 8;
    localparam int BYTE_W = 8;

    // conversion datapath
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W = 4 * BCD_DIGITS;
    localparam int DIGIT_CNT_W = $clog2(BCD_DIGITS + 1);
    localparam int STEP_W = $clog2(NUM_W);
    localparam int PHASE_W = 2;

    // grouping by three digits; (n * 11) >> 5 equals n / 3 for n below 32
    localparam int GROUP_SIZE = 3;
    localparam int GROUP_RECIP = 11;
    localparam int GROUP_SHIFT = 5;
    localparam int GROUPS_W = 3;

    // separator storage
    localparam int MAX_SEPARATOR_BYTES = 4;
    localparam int REG_SEP_BYTES = 4;
    localparam int SEP_LIM = (MAX_SEPARATOR_BYTES < REG_SEP_BYTES) ?
                             MAX_SEPARATOR_BYTES : REG_SEP_BYTES;
    localparam int SEP_LEN_W = $clog2(SEP_LIM + 1);

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SEP_BYTES_W = 32;
    localparam int SEP_LENGTH_W = 3;
    localparam int GROUP_MIN_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MIN = 2'd2;

    localparam logic [SEP_BYTES_W-1:0] RST_SEP_BYTES = 32'd44;
    localparam logic [SEP_LENGTH_W-1:0] RST_SEP_LENGTH = 3'd1;
    localparam logic [GROUP_MIN_W-1:0] RST_GROUP_MIN = 5'd4;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] ASCII_NUL = 8'h00;

    typedef struct packed {
        logic [SEP_BYTES_W-1:0] sep_bytes;
        logic [SEP_LENGTH_W-1:0] sep_length;
        logic [GROUP_MIN_W-1:0] group_min;
    } t_cfg;

    // converter to emitter: finished digits, most significant digit on top
    typedef struct packed {
        logic done;
        logic [BCD_W-1:0] digits;
        logic [DIGIT_CNT_W-1:0] count;
    } t_bcd_res;

    // sequencer to emitter: request attributes held for the whole request
    typedef struct packed {
        logic neg;
        logic [CAP_W-1:0] cap;
    } t_emit_req;

endpackage

`default_nettype wire

// ===== rtl/core/gdr_in_if.sv =====
// gdr_in_if: request channel of the grouped decimal render unit.
// Depends on gdr_pkg.
`default_nettype none

interface gdr_in_if import gdr_pkg::*;;
    logic valid;
    logic ready;
    logic signed [NUM_W-1:0] number;
    logic [CAP_W-1:0] buffer_capacity;

    modport source(output valid, output number, output buffer_capacity, input ready);
    modport sink(input valid, input number, input buffer_capacity, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdr_out_if.sv =====
// gdr_out_if: result channel of the grouped decimal render unit, one text byte per item.
// Depends on gdr_pkg.
`default_nettype none

interface gdr_out_if import gdr_pkg::*;;
    logic valid;
    logic ready;
    logic [BYTE_W-1:0] text_byte;
    logic end_of_text;

    modport source(output valid, output text_byte, output end_of_text, input ready);
    modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/grouped_decimal_render_unit.sv =====
// grouped_decimal_render_unit: top level; configuration registers, request
// sequencer, BCD converter and byte emitter. Depends on gdr_pkg, gdr_in_if,
// gdr_out_if, gdr_bcd_unit, gdr_emitter.
//
//   channel   dir  handshake        payload
//   i_req     in   valid / ready    number (64 signed), buffer_capacity (8)
//   o_res     out  valid / ready    text_byte (8), end_of_text (1)
//   i_cfg_*   in   write enable     index (2), write data (32)
//
// one request at a time: the sequencer takes it, the converter runs shift-add-3
// conversion over all 64 bits, then strips leading zero digits (up to 19) until
// the leading digit is on top, then the emitter sends one text byte per cycle
// (up to 45) while the result side takes every byte
// a request with zero capacity is taken and gives no result
// ready rises again once the NUL byte sits in the output register, so the next
// request is taken while that byte still waits
// reset (synchronous, active low) clears the control state and loads the
// register reset values

`default_nettype none

module grouped_decimal_render_unit import gdr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gdr_in_if.sink                i_req,
    gdr_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic r_state, n_state;
    t_cfg r_cfg, n_cfg;
    t_emit_req r_emit, n_emit;
    t_bcd_res w_bcd;
    logic w_accept;
    logic w_start;
    logic w_emit_done;
    logic [NUM_W-1:0] w_raw;
    logic [NUM_W-1:0] w_mag;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept = i_req.valid && i_req.ready;
    assign w_start = w_accept && (i_req.buffer_capacity != '0);

    assign w_raw = NUM_W'(unsigned'(i_req.number));
    assign w_mag = w_raw[NUM_W-1] ? (~w_raw + NUM_W'(1)) : w_raw;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEP_BYTES: n_cfg.sep_bytes = i_cfg_wdata[SEP_BYTES_W-1:0];
                CFG_SEP_LENGTH: n_cfg.sep_length = i_cfg_wdata[SEP_LENGTH_W-1:0];
                CFG_GROUP_MIN: n_cfg.group_min = i_cfg_wdata[GROUP_MIN_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_emit = r_emit;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_emit.neg = w_raw[NUM_W-1];
                    n_emit.cap = i_req.buffer_capacity;
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg.sep_bytes <= RST_SEP_BYTES;
            r_cfg.sep_length <= RST_SEP_LENGTH;
            r_cfg.group_min <= RST_GROUP_MIN;
        end else begin
            r_state <= n_state;
            r_cfg <= n_cfg;
        end
        r_emit <= n_emit;
    end

    gdr_bcd_unit u_bcd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_magnitude (w_mag),
        .o_res       (w_bcd)
    );

    gdr_emitter u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (r_emit),
        .i_bcd   (w_bcd),
        .o_res   (o_res),
        .o_done  (w_emit_done)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gdr_bcd_unit.sv =====
// gdr_bcd_unit: shift-add-3 binary to BCD converter, one bit per cycle, followed
// by a digit-wide left shift that strips leading zero digits. Depends on gdr_pkg.
`default_nettype none

module gdr_bcd_unit import gdr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_magnitude,
    output t_bcd_res         o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_NORM = 2'd2;

    logic [1:0] r_state, n_state;
    logic [NUM_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DIGIT_CNT_W-1:0] r_count, n_count;
    logic [BCD_W-1:0] w_adj;
    logic [3:0] w_nib;
    logic w_norm_stop;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        w_nib = 4'd0;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            w_nib = r_bcd[4*d +: 4];
            w_adj[4*d +: 4] = (w_nib >= 4'd5) ? 4'(w_nib + 4'd3) : w_nib;
        end
    end

    assign w_norm_stop = (r_count == DIGIT_CNT_W'(1)) || (r_bcd[BCD_W-1 -: 4] != 4'd0);

    always_comb begin
        n_state = r_state;
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_step = r_step;
        n_count = r_count;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_bin = i_magnitude;
                    n_bcd = '0;
                    n_step = '1;
                    n_count = DIGIT_CNT_W'(BCD_DIGITS);
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                {n_bcd, n_bin} = {w_adj[BCD_W-2:0], r_bin, 1'b0};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (w_norm_stop) begin
                    n_state = ST_IDLE;
                end else begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_count = r_count - DIGIT_CNT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_step <= n_step;
        r_count <= n_count;
    end

    assign o_res.done = (r_state == ST_NORM) && w_norm_stop;
    assign o_res.digits = r_bcd;
    assign o_res.count = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/gdr_emitter.sv =====
// gdr_emitter: plans sign, grouping and capacity fit, then sends text one byte
// per cycle when ready, via an output register. Depends on gdr_pkg, gdr_out_if.
`default_nettype none

module gdr_emitter import gdr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_emit_req i_req,
    input  t_bcd_res  i_bcd,
    gdr_out_if.source o_res,
    output logic      o_done
);

    logic r_active, n_active;
    logic r_sign_pend, n_sign_pend;
    logic r_grouped, n_grouped;
    logic [DIGIT_CNT_W-1:0] r_dig_left, n_dig_left;
    logic [BCD_W-1:0] r_digits, n_digits;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [SEP_LEN_W-1:0] r_sep_cnt, n_sep_cnt;
    logic [SEP_BYTES_W-1:0] r_sep_sh, n_sep_sh;
    logic r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic r_last, n_last;

    logic w_slot;
    logic w_run;
    logic [SEP_LEN_W-1:0] w_sep_len;
    logic [DIGIT_CNT_W-1:0] w_cm1;
    logic [7:0] w_grp_prod;
    logic [GROUPS_W-1:0] w_groups;
    logic [DIGIT_CNT_W-1:0] w_rem;
    logic [PHASE_W-1:0] w_phase0;
    logic w_grp_ok;
    logic [5:0] w_written;
    logic [5:0] w_extra;
    logic [6:0] w_needed;
    logic w_fit_grp;
    logic w_fit_bare;
    logic [DIGIT_CNT_W-1:0] w_left_next;

    // separator length: limited by the register and cut at the first zero byte
    always_comb begin
        w_run = 1'b1;
        w_sep_len = '0;
        for (int k = 0; k < SEP_LIM; k++) begin
            if (w_run && (SEP_LENGTH_W'(k) < i_cfg.sep_length) &&
                (i_cfg.sep_bytes[8*k +: 8] != 8'd0)) begin
                w_sep_len = SEP_LEN_W'(k + 1);
            end else begin
                w_run = 1'b0;
            end
        end
    end

    // group count (count - 1) / 3 and position within the first group
    assign w_cm1 = i_bcd.count - DIGIT_CNT_W'(1);
    assign w_grp_prod = 8'(w_cm1) * 8'(GROUP_RECIP);
    assign w_groups = GROUPS_W'(w_grp_prod >> GROUP_SHIFT);
    assign w_rem = i_bcd.count - DIGIT_CNT_W'(DIGIT_CNT_W'(w_groups) * DIGIT_CNT_W'(GROUP_SIZE));
    assign w_phase0 = (w_rem == DIGIT_CNT_W'(GROUP_SIZE)) ? '0 : PHASE_W'(w_rem);

    assign w_grp_ok = (GROUP_MIN_W'(i_bcd.count) >= i_cfg.group_min) &&
                      (w_sep_len != '0) && (w_groups != '0);
    assign w_written = 6'(i_bcd.count) + 6'(i_req.neg);
    assign w_extra = 6'(w_groups) * 6'(w_sep_len);
    assign w_needed = 7'(w_written) + 7'(w_extra);
    assign w_fit_grp = (9'(w_needed) + 9'd1) <= 9'(i_req.cap);
    assign w_fit_bare = (9'(w_written) + 9'd1) <= 9'(i_req.cap);

    assign w_slot = !r_out_valid || o_res.ready;
    assign w_left_next = r_dig_left - DIGIT_CNT_W'(1);

    always_comb begin
        n_active = r_active;
        n_sign_pend = r_sign_pend;
        n_grouped = r_grouped;
        n_dig_left = r_dig_left;
        n_digits = r_digits;
        n_phase = r_phase;
        n_sep_cnt = r_sep_cnt;
        n_sep_sh = r_sep_sh;
        n_out_valid = r_out_valid && !o_res.ready;
        n_byte = r_byte;
        n_last = r_last;
        o_done = 1'b0;
        if (!r_active) begin
            if (i_bcd.done) begin
                n_active = 1'b1;
                n_sign_pend = w_fit_bare && i_req.neg;
                n_grouped = w_grp_ok && w_fit_grp;
                n_dig_left = w_fit_bare ? i_bcd.count : '0;
                n_digits = i_bcd.digits;
                n_phase = w_phase0;
                n_sep_cnt = '0;
            end
        end else if (w_slot) begin
            n_out_valid = 1'b1;
            n_last = 1'b0;
            if (r_sign_pend) begin
                n_byte = ASCII_MINUS;
                n_sign_pend = 1'b0;
            end else if (r_dig_left == '0) begin
                n_byte = ASCII_NUL;
                n_last = 1'b1;
                n_active = 1'b0;
                o_done = 1'b1;
            end else if (r_sep_cnt != '0) begin
                n_byte = r_sep_sh[7:0];
                n_sep_sh = r_sep_sh >> 8;
                n_sep_cnt = r_sep_cnt - SEP_LEN_W'(1);
            end else begin
                n_byte = ASCII_ZERO + BYTE_W'(r_digits[BCD_W-1 -: 4]);
                n_digits = {r_digits[BCD_W-5:0], 4'd0};
                n_dig_left = w_left_next;
                n_phase = (r_phase == '0) ? PHASE_W'(GROUP_SIZE - 1) : r_phase - PHASE_W'(1);
                // a group boundary follows this digit
                if (r_grouped && (r_phase == PHASE_W'(1)) && (w_left_next != '0)) begin
                    n_sep_cnt = w_sep_len;
                    n_sep_sh = i_cfg.sep_bytes;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_sign_pend <= n_sign_pend;
        r_grouped <= n_grouped;
        r_dig_left <= n_dig_left;
        r_digits <= n_digits;
        r_phase <= n_phase;
        r_sep_cnt <= n_sep_cnt;
        r_sep_sh <= n_sep_sh;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.text_byte = r_byte;
    assign o_res.end_of_text = r_last;

endmodule

`default_nettype wire

// ===== tb/grouped_decimal_render_unit_tb.sv =====
// grouped_decimal_render_unit_tb: self-checking bench for the grouped decimal render unit.
// Predicts every text byte in the bench itself and checks each one in order.
// Depends on gdr_pkg, gdr_in_if, gdr_out_if and grouped_decimal_render_unit.

module grouped_decimal_render_unit_tb;
    import gdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 160;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 22;
    localparam int DIGIT_SLOTS = 24;

    typedef struct {
        logic [NUM_W-1:0] number;
        logic [CAP_W-1:0] capacity;
    } t_render_req;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic end_of_text;
    } t_text_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    gdr_in_if req_if ();
    gdr_out_if res_if ();

    grouped_decimal_render_unit u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if),
        .o_res(res_if),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // bench copy of the configuration registers
    logic [SEP_BYTES_W-1:0] sep_bytes_cfg;
    logic [SEP_LENGTH_W-1:0] sep_len_cfg;
    logic [GROUP_MIN_W-1:0] gmin_cfg;

    t_render_req pending_q[$];
    t_text_beat text_expect_q[$];

    int sender_idle_pct = 0;
    int rcv_stall_pct = 0;
    int hold_request = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    int mismatches = 0;
    int reqs_accepted = 0;
    int bytes_checked = 0;
    int grouped_renders = 0;
    int nul_only_renders = 0;
    int silent_renders = 0;
    int cfg_writes = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void report_mismatch(string what, t_text_beat want,
                                            logic [BYTE_W-1:0] got_byte, logic got_last);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, want.text_byte, want.end_of_text, got_byte, got_last);
    endfunction

    function automatic void push_beat(logic [BYTE_W-1:0] b, logic last);
        t_text_beat beat;
        beat.text_byte = b;
        beat.end_of_text = last;
        text_expect_q.push_back(beat);
    endfunction

    // expected text of one request under the current register settings
    function automatic void predict_text(logic [NUM_W-1:0] num, logic [CAP_W-1:0] cap);
        logic [BYTE_W-1:0] digs [DIGIT_SLOTS];
        logic [NUM_W-1:0] mag;
        logic neg;
        int unsigned count, lim, sep_len, groups, written, needed;
        bit grouped, keep;
        if (cap == '0) begin
            silent_renders++;
            return;
        end
        neg = num[NUM_W-1];
        mag = neg ? (~num + 64'd1) : num;
        count = 0;
        do begin
            digs[count] = ASCII_ZERO + 8'(mag % 64'd10);
            mag = mag / 64'd10;
            count++;
        end while (mag != 0 && count < DIGIT_SLOTS);

        lim = sep_len_cfg;
        if (lim > MAX_SEPARATOR_BYTES)
            lim = MAX_SEPARATOR_BYTES;
        if (lim > REG_SEP_BYTES)
            lim = REG_SEP_BYTES;
        // separator ends at its first zero byte
        sep_len = 0;
        while (sep_len < lim && sep_bytes_cfg[8*sep_len +: 8] != 8'h00)
            sep_len++;

        written = count + neg;
        groups = (count - 1) / 3;
        grouped = (count >= gmin_cfg) && (sep_len > 0) && (groups > 0);
        needed = written + (grouped ? groups * sep_len : 0);
        if (needed + 1 > cap) begin
            grouped = 1'b0;
            keep = (written + 1 <= cap);
        end else begin
            keep = 1'b1;
        end

        if (keep) begin
            if (neg)
                push_beat(ASCII_MINUS, 1'b0);
            for (int unsigned i = 0; i < count; i++) begin
                if (grouped && i > 0 && (count - i) % 3 == 0)
                    for (int unsigned k = 0; k < sep_len; k++)
                        push_beat(sep_bytes_cfg[8*k +: 8], 1'b0);
                push_beat(digs[count - 1 - i], 1'b0);
            end
            if (grouped)
                grouped_renders++;
        end else begin
            nul_only_renders++;
        end
        push_beat(ASCII_NUL, 1'b1);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_text(req_if.number, req_if.buffer_capacity);
                void'(pending_q.pop_front());
                reqs_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    req_if.valid <= 1'b1;
                    req_if.number <= pending_q[0].number;
                    req_if.buffer_capacity <= pending_q[0].capacity;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin : result_check
        t_text_beat want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                bytes_checked++;
                if (text_expect_q.size() == 0) begin
                    want = '0;
                    report_mismatch("byte with nothing expected", want,
                                    res_if.text_byte, res_if.end_of_text);
                end else begin
                    want = text_expect_q.pop_front();
                    if (res_if.text_byte !== want.text_byte ||
                        res_if.end_of_text !== want.end_of_text)
                        report_mismatch("text byte mismatch", want,
                                        res_if.text_byte, res_if.end_of_text);
                end
            end
            // long hold-off so the unit backs up and stalls its request side
            if (hold_seen != hold_request) begin
                hold_seen <= hold_request;
                hold_left <= LONG_HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or byte moved for %0d cycles", stall_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void queue_request(logic [NUM_W-1:0] num, logic [CAP_W-1:0] cap);
        t_render_req r;
        r.number = num;
        r.capacity = cap;
        pending_q.push_back(r);
    endfunction

    function automatic logic [NUM_W-1:0] pick_number();
        logic [NUM_W-1:0] lo, mag;
        int unsigned ndig;
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: begin
                case ($urandom_range(3))
                    0: return 64'h8000_0000_0000_0000;
                    1: return 64'h7fff_ffff_ffff_ffff;
                    2: return 64'd0;
                    default: return '1;
                endcase
            end
            default: begin
                // uniform digit count, then a value of that length
                ndig = $urandom_range(1, 19);
                lo = 64'd1;
                repeat (ndig - 1) lo = lo * 64'd10;
                mag = (ndig == 1) ? 64'(0 + $urandom_range(9))
                                  : lo + ({$urandom, $urandom} % (lo * 64'd9));
                mag[NUM_W-1] = 1'b0;
                return $urandom_range(1) ? (~mag + 64'd1) : mag;
            end
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 30)
            return '1;
        // texts run from 2 to 45 bytes, so this lands near the fit limits
        return CAP_W'($urandom_range(1, 48));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        cfg_writes++;
        case (idx)
            CFG_SEP_BYTES: sep_bytes_cfg = data;
            CFG_SEP_LENGTH: sep_len_cfg = data[SEP_LENGTH_W-1:0];
            CFG_GROUP_MIN: gmin_cfg = data[GROUP_MIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [31:0] sep, logic [2:0] len, logic [4:0] gmin);
        write_reg(CFG_SEP_BYTES, sep);
        write_reg(CFG_SEP_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_GROUP_MIN, CFG_DATA_W'(gmin));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_q.size() != 0 || text_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // zero-capacity requests leave no trace in the results, so give the unit time
    task automatic wait_unit_idle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [31:0] sep;
        logic [2:0] len;
        logic [4:0] gmin;
        int profile;

        req_if.valid = 1'b0;
        req_if.number = '0;
        req_if.buffer_capacity = '0;
        res_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SEP_BYTES;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        sep_bytes_cfg = RST_SEP_BYTES;
        sep_len_cfg = RST_SEP_LENGTH;
        gmin_cfg = RST_GROUP_MIN;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: comma every three digits from four digits on
        queue_request(64'd0, 8'd255);
        queue_request(64'd7, 8'd255);
        queue_request(-64'sd1, 8'd255);
        queue_request(64'd999, 8'd255);
        queue_request(64'd1000, 8'd255);
        queue_request(64'd1000, 8'd6);
        queue_request(64'd1000, 8'd5);
        queue_request(64'd1000, 8'd4);
        queue_request(-64'sd1234, 8'd7);
        queue_request(-64'sd1234, 8'd6);
        queue_request(-64'sd1234, 8'd5);
        queue_request(64'd1, 8'd1);
        queue_request(64'd5, 8'd0);
        queue_request(64'h7fff_ffff_ffff_ffff, 8'd255);
        queue_request(64'h8000_0000_0000_0000, 8'd255);
        queue_request(64'h8000_0000_0000_0000, 8'd21);
        queue_request(64'h8000_0000_0000_0000, 8'd20);
        queue_request(64'd123456, 8'd255);
        queue_request(-64'sd1234567, 8'd255);
        queue_request(64'h5555_5555_5555_5555, 8'd255);
        queue_request(64'haaaa_aaaa_aaaa_aaaa, 8'd255);
        queue_request(64'd10, 8'd2);
        queue_request(64'd99, 8'd3);
        queue_request(64'd1000000, 8'd10);
        wait_unit_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin sep = 32'h5f2c_2027; len = 3'd4; gmin = 5'd0;  end
                1: begin sep = 32'hffff_ffff; len = 3'd7; gmin = 5'd20; end
                2: begin sep = 32'h0000_2e2e; len = 3'd4; gmin = 5'd5;  end
                3: begin sep = 32'h0000_0000; len = 3'd0; gmin = 5'd31; end
                4: begin sep = 32'h2e2e_2e00; len = 3'd3; gmin = 5'd1;  end
                default: begin
                    sep = $urandom;
                    if ($urandom_range(3) == 0)
                        sep[8*$urandom_range(3) +: 8] = 8'h00;
                    len = 3'($urandom_range(7));
                    gmin = $urandom_range(1) ? 5'($urandom_range(6)) : 5'($urandom_range(31));
                end
            endcase
            apply_config(sep, len, gmin);

            // idle profiles: none, sender, receiver, both
            profile = (phase + 1) % 4;
            sender_idle_pct = (profile == 1) ? 59 : (profile == 3) ? 28 : 0;
            rcv_stall_pct = (profile == 2) ? 59 : (profile == 3) ? 28 : 0;

            if (phase == 3)
                hold_request++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // in phase 4 the sender waits for every outstanding byte once mid-phase
                if (phase == 4 && k == ITEMS_PER_PHASE / 2)
                    wait_results_drained();
                queue_request(pick_number(), pick_capacity());
            end
            wait_unit_idle();
        end

        if (text_expect_q.size() != 0) begin
            $display("%0d expected bytes never arrived", text_expect_q.size());
            mismatches += text_expect_q.size();
        end
        $display("covered %0d requests: %0d grouped, %0d NUL only, %0d with zero capacity",
                 reqs_accepted, grouped_renders, nul_only_renders, silent_renders);
        $display("checked %0d text bytes over %0d register writes and four idle profiles",
                 bytes_checked, cfg_writes);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
